// File: hw/rtl/rvx_pkg.sv
// ============================================================================
// rvx_pkg - shared types and constants for the RV32I execute block
// Opcode numbering, bus codes, configuration indexes, result layout and
// stream word field positions.
// ============================================================================
`default_nettype none

package rvx_pkg;

    // Register file size default and fixed architectural constants
    localparam int REGISTER_COUNT_DEF = 32;
    localparam int UPPER_SHIFT        = 12;
    localparam logic [31:0] INSTR_BYTES = 32'd4;

    // Input word layout (tdata), lowest bit first
    localparam int IN_OP_LSB    = 0;
    localparam int IN_RD_LSB    = 6;
    localparam int IN_RA_LSB    = 11;
    localparam int IN_RB_LSB    = 16;
    localparam int IN_IMM_LSB   = 21;
    localparam int IN_LDATA_LSB = 53;
    localparam int IN_TDATA_W   = 88;
    localparam int OUT_TDATA_W  = 144;

    // Command carried in tuser
    localparam logic CMD_EXEC      = 1'b0;
    localparam logic CMD_LOAD_RESP = 1'b1;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_SUB, OP_SLT, OP_SLTU, OP_AND, OP_OR, OP_XOR,
        OP_SLL, OP_SRL, OP_SRA, OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI,
        OP_ORI, OP_XORI, OP_SLLI, OP_SRLI, OP_SRAI, OP_BEQ, OP_BGE,
        OP_BGEU, OP_BLT, OP_BLTU, OP_BNE, OP_JAL, OP_JALR, OP_AUIPC,
        OP_LUI, OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB, OP_SH,
        OP_SW, OP_HCF, OP_UNIMPL
    } t_opcode;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_bus_req;

    typedef enum logic [1:0] {
        TGT_MEM   = 2'd0,
        TGT_DMA   = 2'd1,
        TGT_ACCEL = 2'd2
    } t_bus_tgt;

    typedef enum logic [2:0] {
        CFG_DMA_BASE   = 3'd0,
        CFG_DMA_SIZE   = 3'd1,
        CFG_ACCEL_BASE = 3'd2,
        CFG_ACCEL_SIZE = 3'd3,
        CFG_BUF_BASE   = 3'd4,
        CFG_BUF_SIZE   = 3'd5
    } t_cfg_idx;

    // Address window: first byte and one past the last byte (33 bits, no wrap)
    typedef struct packed {
        logic [31:0] base;
        logic [32:0] lim;
    } t_window;

    // Result word; first member sits in the top bits, so pc_value is bit 0
    typedef struct packed {
        logic [31:0] write_value;
        logic [4:0]  write_reg;
        logic        write_enable;
        logic [31:0] store_data;
        logic [2:0]  access_kind;
        logic [1:0]  bus_target;
        logic [31:0] bus_address;
        logic [1:0]  bus_request;
        logic        unimplemented;
        logic        halted;
        logic        retired;
        logic [31:0] pc_value;
    } t_result;

    // Architectural state after one executed word
    typedef struct packed {
        logic [31:0] pc;
        logic        halt;
        logic        load_pend;
    } t_arch_state;

endpackage

`default_nettype wire

// File: hw/rtl/rv32i_execute_with_regfile.sv
// Latency: a word accepted into the input stage register (with its file reads)
// moves to the result register when the execute stage fires; a stalled output holds it.
// Throughput: one word per cycle while the output is not stalled; the register file read, execute and
// write-back loop through the execute stage sets that figure.
// Reset (synchronous, active low) clears PC, halt, pending load, the
// register file valid bits (all registers read zero) and the window registers.
// ============================================================================
// rv32i_execute_with_regfile - RV32I execute stage with register file
// Input register stage with registered file reads, one execute stage that
// updates the architectural state, and an output register stage.
// ============================================================================
`default_nettype none

module rv32i_execute_with_regfile
    import rvx_pkg::*;
#(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input word: opcode, dest_reg, src_reg_a, src_reg_b, immediate, load_data
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: command
    input  wire logic                   s_axis_tuser,
    // result word: pc_value, retired, halted, unimplemented, bus_request,
    // bus_address, bus_target, access_kind, store_data, write_enable,
    // write_reg, write_value
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [2:0]             i_cfg_idx,
    input  wire logic [31:0]            i_cfg_data
);

    // Configuration registers and precomputed window limits
    logic [31:0] r_dma_base, r_dma_size, r_acc_base, r_acc_size;
    logic [31:0] r_buf_base, r_buf_size;
    logic [32:0] r_dma_lim, r_acc_lim, r_buf_lim;
    t_window     dma_win, acc_win, buf_win;

    // Input stage
    logic        r_s1_vld, r_s1_cmd;
    logic [5:0]  r_s1_op;
    logic [4:0]  r_s1_rd;
    logic [31:0] r_s1_imm, r_s1_ldata;

    // Output stage and architectural state
    logic        r_out_vld;
    t_result     r_out;
    t_arch_state r_state;

    logic        s1_fire, in_fire;
    logic [31:0] op_a, op_b, op_d;
    t_result     ex_res;
    t_arch_state n_state;

    assign s1_fire       = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dma_base <= '0;
            r_dma_size <= '0;
            r_acc_base <= '0;
            r_acc_size <= '0;
            r_buf_base <= '0;
            r_buf_size <= '0;
            r_dma_lim  <= '0;
            r_acc_lim  <= '0;
            r_buf_lim  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DMA_BASE:   r_dma_base <= i_cfg_data;
                    CFG_DMA_SIZE:   r_dma_size <= i_cfg_data;
                    CFG_ACCEL_BASE: r_acc_base <= i_cfg_data;
                    CFG_ACCEL_SIZE: r_acc_size <= i_cfg_data;
                    CFG_BUF_BASE:   r_buf_base <= i_cfg_data;
                    CFG_BUF_SIZE:   r_buf_size <= i_cfg_data;
                    default: ;
                endcase
            end
            // window end, one past the last byte; a zero size gives an empty window
            r_dma_lim <= {1'b0, r_dma_base} + {1'b0, r_dma_size};
            r_acc_lim <= {1'b0, r_acc_base} + {1'b0, r_acc_size};
            r_buf_lim <= {1'b0, r_buf_base} + {1'b0, r_buf_size};
        end
    end

    assign dma_win = '{base: r_dma_base, lim: r_dma_lim};
    assign acc_win = '{base: r_acc_base, lim: r_acc_lim};
    assign buf_win = '{base: r_buf_base, lim: r_buf_lim};

    // Input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd   <= s_axis_tuser;
            r_s1_op    <= s_axis_tdata[IN_OP_LSB +: 6];
            r_s1_rd    <= s_axis_tdata[IN_RD_LSB +: 5];
            r_s1_imm   <= s_axis_tdata[IN_IMM_LSB +: 32];
            r_s1_ldata <= s_axis_tdata[IN_LDATA_LSB +: 32];
        end
    end

    // Register file, read at accept, written when the execute stage fires
    rvx_regfile #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_fire),
        .i_addr_a (s_axis_tdata[IN_RA_LSB +: 5]),
        .i_addr_b (s_axis_tdata[IN_RB_LSB +: 5]),
        .i_addr_d (s_axis_tdata[IN_RD_LSB +: 5]),
        .i_we     (s1_fire && ex_res.write_enable),
        .i_waddr  (ex_res.write_reg),
        .i_wdata  (ex_res.write_value),
        .o_data_a (op_a),
        .o_data_b (op_b),
        .o_data_d (op_d)
    );

    // Execute
    rvx_exec #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_exec (
        .i_cmd       (r_s1_cmd),
        .i_opcode    (r_s1_op),
        .i_dest_reg  (r_s1_rd),
        .i_imm       (r_s1_imm),
        .i_load_data (r_s1_ldata),
        .i_op_a      (op_a),
        .i_op_b      (op_b),
        .i_op_d      (op_d),
        .i_state     (r_state),
        .i_dma_win   (dma_win),
        .i_accel_win (acc_win),
        .i_buf_win   (buf_win),
        .o_res       (ex_res),
        .o_state     (n_state)
    );

    // Architectural state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_state <= n_state;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= ex_res;
        end
    end

    // Register zero is never written
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && ex_res.write_enable) |-> (ex_res.write_reg != 5'd0))
        else $error("register zero written");

    // Nothing is written once halted
    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_state.halt) |-> (!ex_res.write_enable && !ex_res.retired))
        else $error("state changed while halted");

    // A read request leaves a load pending
    a_load_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && ex_res.bus_request == REQ_READ) |=> r_state.load_pend)
        else $error("read request without pending load");

    // An execute word is not retired while a load is pending
    a_pend_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_state.load_pend && r_s1_cmd == CMD_EXEC) |-> !ex_res.retired)
        else $error("instruction retired while load pending");

    // Input is held off only while the input and output stages are both occupied
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_vld && r_out_vld))
        else $error("input stalled with free stage");

endmodule

`default_nettype wire

// File: hw/rtl/rvx_regfile.sv
// ============================================================================
// rvx_regfile - register file with registered reads
// Two copies of the array give three read ports (a, b and d); reads are
// registered at word accept, with valid bits standing in for reset and a
// bypass for a write landing on the same edge. Register zero reads zero.
// ============================================================================
`default_nettype none

module rvx_regfile
    import rvx_pkg::*;
#(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [4:0]  i_addr_a,
    input  wire logic [4:0]  i_addr_b,
    input  wire logic [4:0]  i_addr_d,
    input  wire logic        i_we,
    input  wire logic [4:0]  i_waddr,
    input  wire logic [31:0] i_wdata,
    output logic      [31:0] o_data_a,
    output logic      [31:0] o_data_b,
    output logic      [31:0] o_data_d
);

    localparam int IW = $clog2(REGISTER_COUNT);

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_FWD  = 2'd2
    } t_rd_src;

    logic [31:0] r_mem_ab [REGISTER_COUNT];
    logic [31:0] r_mem_d  [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_valid;

    logic [31:0] r_q_a, r_q_b, r_q_d, r_fwd;
    t_rd_src     r_src_a, r_src_b, r_src_d;
    t_rd_src     n_src_a, n_src_b, n_src_d;

    function automatic t_rd_src rd_src(
        input logic [4:0] addr,
        input logic       we,
        input logic [4:0] waddr,
        input logic [REGISTER_COUNT-1:0] valid
    );
        t_rd_src src;
        src = SRC_ZERO;
        if (addr != 5'd0 && {1'b0, addr} < 6'(REGISTER_COUNT)) begin
            if (we && waddr == addr) begin
                src = SRC_FWD;
            end else if (valid[addr[IW-1:0]]) begin
                src = SRC_MEM;
            end
        end
        return src;
    endfunction

    // Read source selection at accept time
    always_comb begin
        n_src_a = rd_src(i_addr_a, i_we, i_waddr, r_valid);
        n_src_b = rd_src(i_addr_b, i_we, i_waddr, r_valid);
        n_src_d = rd_src(i_addr_d, i_we, i_waddr, r_valid);
    end

    // Array writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_ab[i_waddr[IW-1:0]] <= i_wdata;
            r_mem_d[i_waddr[IW-1:0]]  <= i_wdata;
        end
        if (i_rd_en) begin
            r_q_a <= r_mem_ab[i_addr_a[IW-1:0]];
            r_q_b <= r_mem_ab[i_addr_b[IW-1:0]];
            r_q_d <= r_mem_d[i_addr_d[IW-1:0]];
            r_fwd <= i_wdata;
        end
    end

    // Valid bits and read source flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_src_a <= SRC_ZERO;
            r_src_b <= SRC_ZERO;
            r_src_d <= SRC_ZERO;
        end else begin
            if (i_we) begin
                r_valid[i_waddr[IW-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_src_a <= n_src_a;
                r_src_b <= n_src_b;
                r_src_d <= n_src_d;
            end
        end
    end

    // Output select
    always_comb begin
        case (r_src_a)
            SRC_MEM: o_data_a = r_q_a;
            SRC_FWD: o_data_a = r_fwd;
            default: o_data_a = '0;
        endcase
        case (r_src_b)
            SRC_MEM: o_data_b = r_q_b;
            SRC_FWD: o_data_b = r_fwd;
            default: o_data_b = '0;
        endcase
        case (r_src_d)
            SRC_MEM: o_data_d = r_q_d;
            SRC_FWD: o_data_d = r_fwd;
            default: o_data_d = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/rvx_exec.sv
// ============================================================================
// rvx_exec - combinational execute of one word
// ALU, branch and jump resolution, load/store request with window decode,
// HCF and load response handling. Produces the result word and next state.
// ============================================================================
`default_nettype none

module rvx_exec
    import rvx_pkg::*;
#(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  wire logic        i_cmd,
    input  wire logic [5:0]  i_opcode,
    input  wire logic [4:0]  i_dest_reg,
    input  wire logic [31:0] i_imm,
    input  wire logic [31:0] i_load_data,
    input  wire logic [31:0] i_op_a,
    input  wire logic [31:0] i_op_b,
    input  wire logic [31:0] i_op_d,
    input  wire t_arch_state i_state,
    input  wire t_window     i_dma_win,
    input  wire t_window     i_accel_win,
    input  wire t_window     i_buf_win,
    output t_result          o_res,
    output t_arch_state      o_state
);

    logic [31:0] next_pc, res_val, pc_inc, addr;
    logic        has_res, commit, wr_ok;
    logic        hit_dma, hit_accel, hit_buf;

    function automatic logic win_hit(input logic [31:0] a, input t_window w);
        return (a >= w.base) && ({1'b0, a} < w.lim);
    endfunction

    // Load/store address and window decode
    assign addr      = i_op_a + i_imm;
    assign hit_dma   = win_hit(addr, i_dma_win);
    assign hit_accel = win_hit(addr, i_accel_win);
    assign hit_buf   = win_hit(addr, i_buf_win);
    assign pc_inc    = i_state.pc + INSTR_BYTES;
    assign wr_ok     = (i_dest_reg != 5'd0) && ({1'b0, i_dest_reg} < 6'(REGISTER_COUNT));

    // Main execute
    always_comb begin
        o_res   = '0;
        o_state = i_state;
        next_pc = pc_inc;
        res_val = '0;
        has_res = 1'b0;
        commit  = 1'b0;

        if (i_state.halt) begin
            // halted: no change
        end else if (i_cmd == CMD_LOAD_RESP) begin
            if (i_state.load_pend) begin
                has_res           = 1'b1;
                res_val           = i_load_data;
                o_state.load_pend = 1'b0;
                commit            = 1'b1;
            end
        end else if (!i_state.load_pend) begin
            commit = 1'b1;
            case (t_opcode'(i_opcode))
                OP_ADD:   begin res_val = i_op_a + i_op_b;  has_res = 1'b1; end
                OP_SUB:   begin res_val = i_op_a - i_op_b;  has_res = 1'b1; end
                OP_SLT:   begin
                    res_val = {31'd0, $signed(i_op_a) < $signed(i_op_b)};
                    has_res = 1'b1;
                end
                OP_SLTU:  begin res_val = {31'd0, i_op_a < i_op_b}; has_res = 1'b1; end
                OP_AND:   begin res_val = i_op_a & i_op_b;  has_res = 1'b1; end
                OP_OR:    begin res_val = i_op_a | i_op_b;  has_res = 1'b1; end
                OP_XOR:   begin res_val = i_op_a ^ i_op_b;  has_res = 1'b1; end
                OP_SLL:   begin res_val = i_op_a << i_op_b[4:0]; has_res = 1'b1; end
                OP_SRL:   begin res_val = i_op_a >> i_op_b[4:0]; has_res = 1'b1; end
                OP_SRA:   begin
                    res_val = 32'($signed(i_op_a) >>> i_op_b[4:0]);
                    has_res = 1'b1;
                end
                OP_ADDI:  begin res_val = i_op_a + i_imm;   has_res = 1'b1; end
                OP_SLTI:  begin
                    res_val = {31'd0, $signed(i_op_a) < $signed(i_imm)};
                    has_res = 1'b1;
                end
                OP_SLTIU: begin res_val = {31'd0, i_op_a < i_imm}; has_res = 1'b1; end
                OP_ANDI:  begin res_val = i_op_a & i_imm;   has_res = 1'b1; end
                OP_ORI:   begin res_val = i_op_a | i_imm;   has_res = 1'b1; end
                OP_XORI:  begin res_val = i_op_a ^ i_imm;   has_res = 1'b1; end
                OP_SLLI:  begin res_val = i_op_a << i_imm[4:0]; has_res = 1'b1; end
                OP_SRLI:  begin res_val = i_op_a >> i_imm[4:0]; has_res = 1'b1; end
                OP_SRAI:  begin
                    res_val = 32'($signed(i_op_a) >>> i_imm[4:0]);
                    has_res = 1'b1;
                end
                // branches compare the operand read through dest_reg against operand a
                OP_BEQ:   if (i_op_d == i_op_a) next_pc = i_imm;
                OP_BGE:   if (!($signed(i_op_d) < $signed(i_op_a))) next_pc = i_imm;
                OP_BGEU:  if (i_op_d >= i_op_a) next_pc = i_imm;
                OP_BLT:   if ($signed(i_op_d) < $signed(i_op_a)) next_pc = i_imm;
                OP_BLTU:  if (i_op_d < i_op_a) next_pc = i_imm;
                OP_BNE:   if (i_op_d != i_op_a) next_pc = i_imm;
                OP_JAL:   begin res_val = pc_inc; has_res = 1'b1; next_pc = i_imm; end
                OP_JALR:  begin res_val = pc_inc; has_res = 1'b1; next_pc = addr; end
                OP_AUIPC: begin
                    res_val = i_state.pc + (i_imm << UPPER_SHIFT);
                    has_res = 1'b1;
                end
                OP_LUI:   begin res_val = i_imm << UPPER_SHIFT; has_res = 1'b1; end
                OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW,
                OP_SB, OP_SH, OP_SW: begin
                    o_res.bus_address = addr;
                    o_res.access_kind = 3'(i_opcode - OP_LB);
                    if (hit_dma) begin
                        o_res.bus_target = TGT_DMA;
                    end else if (hit_accel || hit_buf) begin
                        o_res.bus_target = TGT_ACCEL;
                    end else begin
                        o_res.bus_target = TGT_MEM;
                    end
                    if (i_opcode inside {[OP_LB:OP_LW]}) begin
                        // load waits for its response word
                        o_res.bus_request = REQ_READ;
                        o_state.load_pend = 1'b1;
                        commit            = 1'b0;
                    end else begin
                        o_res.bus_request = REQ_WRITE;
                        o_res.store_data  = i_op_d;
                    end
                end
                OP_HCF:   o_state.halt = 1'b1;
                default:  o_res.unimplemented = 1'b1;
            endcase
        end

        // register write-back
        if (has_res && wr_ok) begin
            o_res.write_enable = 1'b1;
            o_res.write_reg    = i_dest_reg;
            o_res.write_value  = res_val;
        end
        if (commit) begin
            o_res.retired = 1'b1;
            o_state.pc    = next_pc;
        end
        o_res.pc_value = o_state.pc;
        o_res.halted   = o_state.halt;
    end

endmodule

`default_nettype wire
